// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/srau_pkg.sv =====
// Package with opcodes, shift types, error codes and stream widths of the shifted register ALU.
package srau_pkg;

    localparam logic [31:0] PC_READ_OFFSET = 32'd8;
    localparam logic [3:0]  PC_INDEX       = 4'hF;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_SUB = 4'h2,
        OP_ADD = 4'h4,
        OP_CMP = 4'hA,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE
    } opcode_t;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_type_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDEF_OP  = 2'd1,
        ERR_ROTATE    = 2'd2
    } error_code_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] first_operand;
        logic [31:0] second_operand;
        logic [31:0] shift_register_value;
        logic        carry_in;
        logic        overflow_in;
    } in_item_t;

    typedef struct packed {
        error_code_t error_code;
        logic        flags_write;
        logic        flag_v;
        logic        flag_c;
        logic        flag_z;
        logic        flag_n;
        logic        write_enable;
        logic [3:0]  dest_register;
        logic [31:0] result_value;
    } out_item_t;

endpackage

// ===== rtl/core/shifted_register_alu_unit.sv =====
// Shifted register ALU (decode, barrel shift, ALU): one instruction per cycle unless stalled.
//
//   channel  | direction | tdata fields (lowest bit first)
//   ---------+-----------+-----------------------------------------------------------
//   s_axis   | in        | instruction, first_operand, second_operand,
//            |           | shift_register_value, carry_in, overflow_in, zero pad
//   m_axis   | out       | result_value, dest_register, write_enable, flag_n, flag_z,
//            |           | flag_c, flag_v, flags_write, error_code, zero pad
//
// One request is taken every cycle unless the output stalls; a request is held in the input
// register and its result in the result register, around the shift and add logic.
// Reset clears both valid bits; the block is ready as soon as reset is released.
// A stalled result holds in the result register while the input register takes the
// next request, so one request can wait behind a stalled result.
module shifted_register_alu_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // instruction[31:0], first_operand[63:32], second_operand[95:64],
    // shift_register_value[127:96], carry_in[128], overflow_in[129], zeros[135:130]
    input  logic [srau_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // result_value[31:0], dest_register[35:32], write_enable[36], flag_n[37],
    // flag_z[38], flag_c[39], flag_v[40], flags_write[41], error_code[43:42], zeros[47:44]
    output logic [srau_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    srau_pkg::in_item_t  in_reg;
    srau_pkg::in_item_t  in_next;
    logic                in_valid_reg;
    srau_pkg::out_item_t out_reg;
    srau_pkg::out_item_t out_next;
    logic                out_valid_reg;
    logic                out_load;
    logic                in_load;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    assign in_next.instruction          = s_axis_tdata[31:0];
    assign in_next.first_operand        = s_axis_tdata[63:32];
    assign in_next.second_operand       = s_axis_tdata[95:64];
    assign in_next.shift_register_value = s_axis_tdata[127:96];
    assign in_next.carry_in             = s_axis_tdata[128];
    assign in_next.overflow_in          = s_axis_tdata[129];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg <= in_next;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        srau_pkg::opcode_t     op;
        srau_pkg::shift_type_t sh_type;
        logic [3:0]            rn;
        logic [3:0]            rm;
        logic [4:0]            imm;
        logic [7:0]            amt;
        logic                  amt_big;
        logic [31:0]           a;
        logic [31:0]           b;
        logic [32:0]           lsl_w;
        logic [32:0]           lsr_w;
        logic signed [32:0]    asr_w;
        logic [31:0]           shifted;
        logic                  sc;
        logic [32:0]           sum;
        logic                  op_ok;

        op      = srau_pkg::opcode_t'(in_reg.instruction[24:21]);
        sh_type = srau_pkg::shift_type_t'(in_reg.instruction[6:5]);
        rn      = in_reg.instruction[19:16];
        rm      = in_reg.instruction[3:0];
        imm     = in_reg.instruction[11:7];

        // An immediate amount of zero means 32 for the right shifts.
        if (in_reg.instruction[4])
        begin
            amt = in_reg.shift_register_value[7:0];
        end
        else if (imm == 5'd0 && sh_type != srau_pkg::SHIFT_LSL)
        begin
            amt = 8'd32;
        end
        else
        begin
            amt = {3'b000, imm};
        end
        amt_big = (amt[7:5] != 3'b000);

        a = (rn == srau_pkg::PC_INDEX) ? in_reg.first_operand + srau_pkg::PC_READ_OFFSET
                                       : in_reg.first_operand;
        b = (rm == srau_pkg::PC_INDEX) ? in_reg.second_operand + srau_pkg::PC_READ_OFFSET
                                       : in_reg.second_operand;

        // The extra bit beside the word catches the last bit shifted out.
        lsl_w = {1'b0, b} << amt[4:0];
        lsr_w = {b, 1'b0} >> amt[4:0];
        asr_w = $signed({b, 1'b0}) >>> amt[4:0];

        if (amt == 8'd0)
        begin
            shifted = b;
            sc      = in_reg.carry_in;
        end
        else
        begin
            unique case (sh_type)
                srau_pkg::SHIFT_LSL:
                begin
                    shifted = amt_big ? 32'd0 : lsl_w[31:0];
                    sc      = amt_big ? ((amt == 8'd32) ? b[0] : 1'b0) : lsl_w[32];
                end
                srau_pkg::SHIFT_LSR:
                begin
                    shifted = amt_big ? 32'd0 : lsr_w[32:1];
                    sc      = amt_big ? ((amt == 8'd32) ? b[31] : 1'b0) : lsr_w[0];
                end
                default:
                begin
                    shifted = amt_big ? {32{b[31]}} : asr_w[32:1];
                    sc      = amt_big ? b[31] : asr_w[0];
                end
            endcase
        end

        if (op == srau_pkg::OP_ADD)
        begin
            sum = {1'b0, a} + {1'b0, shifted};
        end
        else
        begin
            sum = {1'b0, a} + {1'b0, ~shifted} + 33'd1;
        end

        out_next               = '0;
        out_next.dest_register = in_reg.instruction[15:12];
        out_next.write_enable  = 1'b1;
        out_next.flags_write   = in_reg.instruction[20];
        out_next.flag_v        = in_reg.overflow_in;
        op_ok                  = 1'b1;

        unique case (op)
            srau_pkg::OP_AND:
            begin
                out_next.result_value = a & shifted;
                out_next.flag_c       = sc;
            end
            srau_pkg::OP_ORR:
            begin
                out_next.result_value = a | shifted;
                out_next.flag_c       = sc;
            end
            srau_pkg::OP_MOV:
            begin
                out_next.result_value = shifted;
                out_next.flag_c       = sc;
            end
            srau_pkg::OP_BIC:
            begin
                out_next.result_value = a & ~shifted;
                out_next.flag_c       = sc;
            end
            srau_pkg::OP_ADD:
            begin
                out_next.result_value = sum[31:0];
                out_next.flag_c       = sum[32];
                out_next.flag_v       = ~(a[31] ^ shifted[31]) & (a[31] ^ sum[31]);
            end
            srau_pkg::OP_SUB,
            srau_pkg::OP_CMP:
            begin
                // The carry out of a + ~b + 1 is the not-borrow flag.
                out_next.result_value = sum[31:0];
                out_next.flag_c       = sum[32];
                out_next.flag_v       = (a[31] ^ shifted[31]) & (a[31] ^ sum[31]);
                if (op == srau_pkg::OP_CMP)
                begin
                    out_next.write_enable  = 1'b0;
                    out_next.flags_write   = 1'b1;
                    out_next.dest_register = 4'd0;
                end
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase

        out_next.flag_n = out_next.result_value[31];
        out_next.flag_z = (out_next.result_value == 32'd0);

        if (!op_ok)
        begin
            out_next            = '0;
            out_next.error_code = srau_pkg::ERR_UNDEF_OP;
        end
        else if (sh_type == srau_pkg::SHIFT_ROR)
        begin
            out_next            = '0;
            out_next.error_code = srau_pkg::ERR_ROTATE;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg};

endmodule

// ===== rtl/core/srau_checker.sv =====
// Port-level checker for the shifted register ALU and its bind to the top level.
`include "assert_macros.svh"

module srau_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [srau_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [srau_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic [1:0] err;
    logic       ok_item;

    assign err     = m_axis_tdata[43:42];
    assign ok_item = m_axis_tvalid && (err == srau_pkg::ERR_NONE);

    // A result waiting on the downstream side must not change.
    `ASSERT_HOLDS(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // A faulted request carries nothing but its error code.
    `ASSERT_HOLDS(a_err_clean, clk, rst_n, m_axis_tvalid && (err != srau_pkg::ERR_NONE) |-> (m_axis_tdata[41:0] == 42'd0) && (err != 2'd3), "faulted result not clean")

    // The zero and negative flags follow the delivered result value.
    `ASSERT_HOLDS(a_nz_flags, clk, rst_n, ok_item |-> (m_axis_tdata[38] == (m_axis_tdata[31:0] == 32'd0)) && (m_axis_tdata[37] == m_axis_tdata[31]), "N or Z flag wrong")

    // A compare writes no register but always writes flags.
    `ASSERT_NEVER(a_cmp_form, clk, rst_n, ok_item && !m_axis_tdata[36] && ((m_axis_tdata[35:32] != 4'd0) || !m_axis_tdata[41]), "compare result malformed")

endmodule

bind shifted_register_alu_unit srau_checker u_srau_checker (.*);

// ===== tb/srau_result_checker.sv =====
// Checker for the shifted register ALU: predicts each result from the accepted requests and compares.
module srau_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [srau_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [srau_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                               fail_count,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0]           value;
        logic [3:0]            dest;
        logic                  we;
        logic                  n;
        logic                  z;
        logic                  c;
        logic                  v;
        logic                  fw;
        srau_pkg::error_code_t err;
    } alu_outcome_t;

    alu_outcome_t expected_results[$];
    alu_outcome_t want;
    int           result_index = 0;

    function automatic alu_outcome_t predict_alu_result(
        input logic [31:0] insn,
        input logic [31:0] rn_val,
        input logic [31:0] rm_val,
        input logic [31:0] rs_val,
        input logic        cin,
        input logic        vin
    );
        alu_outcome_t          r;
        srau_pkg::shift_type_t kind;
        logic [3:0]            op;
        logic                  legal;
        int                    amount;
        logic [31:0]           a;
        logic [31:0]           b;
        logic [31:0]           shifted;
        logic                  shift_carry;
        logic [32:0]           sum;
        r    = '0;
        op   = insn[24:21];
        kind = srau_pkg::shift_type_t'(insn[6:5]);
        case (op)
            srau_pkg::OP_AND, srau_pkg::OP_SUB, srau_pkg::OP_ADD, srau_pkg::OP_CMP,
            srau_pkg::OP_ORR, srau_pkg::OP_MOV, srau_pkg::OP_BIC: legal = 1'b1;
            default: legal = 1'b0;
        endcase
        // An undefined opcode wins over a rotate shift type.
        if (!legal)
        begin
            r.err = srau_pkg::ERR_UNDEF_OP;
            return r;
        end
        if (kind == srau_pkg::SHIFT_ROR)
        begin
            r.err = srau_pkg::ERR_ROTATE;
            return r;
        end

        // An immediate of zero means 32 for the right shifts.
        if (insn[4])
            amount = rs_val[7:0];
        else if (insn[11:7] == 5'd0 && kind != srau_pkg::SHIFT_LSL)
            amount = 32;
        else
            amount = insn[11:7];

        a = rn_val + ((insn[19:16] == srau_pkg::PC_INDEX) ? srau_pkg::PC_READ_OFFSET : 32'd0);
        b = rm_val + ((insn[3:0] == srau_pkg::PC_INDEX) ? srau_pkg::PC_READ_OFFSET : 32'd0);

        if (amount == 0)
        begin
            shifted     = b;
            shift_carry = cin;
        end
        else
        begin
            case (kind)
                srau_pkg::SHIFT_LSL:
                begin
                    if (amount < 32)
                    begin
                        shifted     = b << amount;
                        shift_carry = b[32 - amount];
                    end
                    else
                    begin
                        shifted     = 32'd0;
                        shift_carry = (amount == 32) ? b[0] : 1'b0;
                    end
                end
                srau_pkg::SHIFT_LSR:
                begin
                    if (amount < 32)
                    begin
                        shifted     = b >> amount;
                        shift_carry = b[amount - 1];
                    end
                    else
                    begin
                        shifted     = 32'd0;
                        shift_carry = (amount == 32) ? b[31] : 1'b0;
                    end
                end
                default:
                begin
                    if (amount < 32)
                    begin
                        shifted     = $unsigned($signed(b) >>> amount);
                        shift_carry = b[amount - 1];
                    end
                    else
                    begin
                        shifted     = {32{b[31]}};
                        shift_carry = b[31];
                    end
                end
            endcase
        end

        r.we   = 1'b1;
        r.fw   = insn[20];
        r.dest = insn[15:12];
        r.v    = vin;
        case (op)
            srau_pkg::OP_AND:
            begin
                r.value = a & shifted;
                r.c     = shift_carry;
            end
            srau_pkg::OP_ORR:
            begin
                r.value = a | shifted;
                r.c     = shift_carry;
            end
            srau_pkg::OP_MOV:
            begin
                r.value = shifted;
                r.c     = shift_carry;
            end
            srau_pkg::OP_BIC:
            begin
                r.value = a & ~shifted;
                r.c     = shift_carry;
            end
            srau_pkg::OP_ADD:
            begin
                sum     = {1'b0, a} + {1'b0, shifted};
                r.value = sum[31:0];
                r.c     = sum[32];
                r.v     = ~(a[31] ^ shifted[31]) & (a[31] ^ sum[31]);
            end
            default:
            begin
                r.value = a - shifted;
                r.c     = (a >= shifted);
                r.v     = (a[31] ^ shifted[31]) & (a[31] ^ r.value[31]);
                if (op == srau_pkg::OP_CMP)
                begin
                    r.we   = 1'b0;
                    r.fw   = 1'b1;
                    r.dest = 4'd0;
                end
            end
        endcase
        r.n = r.value[31];
        r.z = (r.value == 32'd0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $time, result_index, what, got, exp_val);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Results are taken before requests so that a result never meets its own request.
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result_value", m_tdata[31:0], 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_value", m_tdata[31:0], want.value);
                    check_field("dest_register", 32'(m_tdata[35:32]), 32'(want.dest));
                    check_field("write_enable", 32'(m_tdata[36]), 32'(want.we));
                    check_field("flag_n", 32'(m_tdata[37]), 32'(want.n));
                    check_field("flag_z", 32'(m_tdata[38]), 32'(want.z));
                    check_field("flag_c", 32'(m_tdata[39]), 32'(want.c));
                    check_field("flag_v", 32'(m_tdata[40]), 32'(want.v));
                    check_field("flags_write", 32'(m_tdata[41]), 32'(want.fw));
                    check_field("error_code", 32'(m_tdata[43:42]), 32'(want.err));
                end
                result_index++;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_alu_result(s_tdata[31:0], s_tdata[63:32],
                                                              s_tdata[95:64], s_tdata[127:96],
                                                              s_tdata[128], s_tdata[129]));
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/shifted_register_alu_unit_tb.sv =====
// Testbench top for the shifted register ALU: stimulus, flow control and the final verdict.
module shifted_register_alu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_COUNT = 2000;
    localparam int QUIET_TAIL   = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 60;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [srau_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [srau_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int sent_count  = 0;
    int cycle_count = 0;
    bit quiet_phase = 1'b0;

    srau_pkg::opcode_t legal_ops[7] = '{srau_pkg::OP_AND, srau_pkg::OP_SUB, srau_pkg::OP_ADD,
                                        srau_pkg::OP_CMP, srau_pkg::OP_ORR, srau_pkg::OP_MOV,
                                        srau_pkg::OP_BIC};

    shifted_register_alu_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    srau_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] encode_insn(
        input int                    op,
        input int                    s,
        input int                    rn,
        input int                    rd,
        input int                    shamt,
        input srau_pkg::shift_type_t kind,
        input int                    byreg,
        input int                    rs,
        input int                    rm
    );
        return {4'hE, 3'b000, 4'(op), 1'(s), 4'(rn), 4'(rd),
                (byreg != 0) ? {4'(rs), 1'b0} : 5'(shamt), kind, 1'(byreg), 4'(rm)};
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_shift_reg();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v[7:0] = 8'($urandom_range(0, 40));
            6: v[7:0] = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input logic [31:0] insn, input logic [31:0] rn_val,
                                input logic [31:0] rm_val, input logic [31:0] rs_val,
                                input int cin, input int vin);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, 1'(vin), 1'(cin), rs_val, rm_val, rn_val, insn};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic maybe_idle_sender();
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        send_request(encode_insn(srau_pkg::OP_AND, 1, 1, 2, 0, srau_pkg::SHIFT_LSL, 0, 0, 2),
                     32'hFFFF_FFFF, 32'h0F0F_F0F0, 32'h0, 1, 1);
        send_request(encode_insn(srau_pkg::OP_SUB, 1, 3, 4, 1, srau_pkg::SHIFT_LSL, 0, 0, 5),
                     32'h0, 32'h1, 32'h0, 0, 0);
        maybe_idle_sender();
        send_request(encode_insn(srau_pkg::OP_ADD, 1, 0, 0, 0, srau_pkg::SHIFT_LSL, 0, 0, 1),
                     32'hFFFF_FFFF, 32'h1, 32'h0, 0, 1);
        send_request(encode_insn(srau_pkg::OP_ADD, 1, 6, 9, 0, srau_pkg::SHIFT_LSL, 0, 0, 7),
                     32'h7FFF_FFFF, 32'h1, 32'h0, 1, 0);
        send_request(encode_insn(srau_pkg::OP_CMP, 0, 2, 3, 0, srau_pkg::SHIFT_LSL, 0, 0, 4),
                     32'h5, 32'h5, 32'h0, 0, 0);
        send_request(encode_insn(srau_pkg::OP_CMP, 1, 2, 7, 0, srau_pkg::SHIFT_LSL, 0, 0, 4),
                     32'h8000_0000, 32'h1, 32'h0, 1, 0);
        // Right shifts with an immediate of zero act as shifts by 32.
        send_request(encode_insn(srau_pkg::OP_ORR, 1, 1, 14, 0, srau_pkg::SHIFT_LSR, 0, 0, 2),
                     32'h0, 32'h8000_0000, 32'h0, 0, 1);
        send_request(encode_insn(srau_pkg::OP_MOV, 1, 0, 1, 0, srau_pkg::SHIFT_ASR, 0, 0, 2),
                     32'h0, 32'h8000_0001, 32'h0, 0, 0);
        send_request(encode_insn(srau_pkg::OP_BIC, 1, 1, 1, 0, srau_pkg::SHIFT_ASR, 0, 0, 2),
                     32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1, 1);
        send_request(encode_insn(srau_pkg::OP_MOV, 1, 0, 15, 31, srau_pkg::SHIFT_LSL, 0, 0, 2),
                     32'h0, 32'h0000_0003, 32'h0, 0, 0);
        maybe_idle_sender();
        send_request(encode_insn(srau_pkg::OP_MOV, 1, 0, 2, 0, srau_pkg::SHIFT_ASR, 1, 3, 2),
                     32'h0, 32'h8000_0000, 32'hFFFF_FF00, 1, 0);
        send_request(encode_insn(srau_pkg::OP_MOV, 1, 0, 2, 0, srau_pkg::SHIFT_LSL, 1, 3, 2),
                     32'h0, 32'h0000_0001, 32'h0000_0020, 0, 0);
        send_request(encode_insn(srau_pkg::OP_MOV, 1, 0, 2, 0, srau_pkg::SHIFT_LSR, 1, 3, 2),
                     32'h0, 32'h8000_0000, 32'h0000_0020, 0, 0);
        send_request(encode_insn(srau_pkg::OP_MOV, 1, 0, 2, 0, srau_pkg::SHIFT_LSL, 1, 3, 2),
                     32'h0, 32'hFFFF_FFFF, 32'h0000_0021, 1, 0);
        send_request(encode_insn(srau_pkg::OP_MOV, 1, 0, 2, 0, srau_pkg::SHIFT_LSR, 1, 3, 2),
                     32'h0, 32'hFFFF_FFFF, 32'h0000_00FF, 1, 1);
        send_request(encode_insn(srau_pkg::OP_MOV, 1, 0, 2, 0, srau_pkg::SHIFT_ASR, 1, 3, 2),
                     32'h0, 32'h8000_0000, 32'h0000_00C8, 0, 0);
        // Index 15 reads the program counter with its offset; Rs index 15 does not.
        send_request(encode_insn(srau_pkg::OP_ADD, 1, 15, 3, 0, srau_pkg::SHIFT_LSL, 0, 0, 15),
                     32'hFFFF_FFF8, 32'hFFFF_FFF8, 32'h0, 0, 0);
        send_request(encode_insn(srau_pkg::OP_SUB, 1, 1, 3, 0, srau_pkg::SHIFT_LSR, 1, 15, 2),
                     32'h100, 32'hF0, 32'h4, 1, 1);
        send_request(encode_insn(srau_pkg::OP_MOV, 0, 15, 3, 2, srau_pkg::SHIFT_LSL, 0, 0, 4),
                     32'h1234_5678, 32'h1, 32'h0, 0, 1);
        maybe_idle_sender();
        send_request(encode_insn(4'h1, 1, 1, 2, 0, srau_pkg::SHIFT_LSL, 0, 0, 3),
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, 1);
        send_request(encode_insn(4'hF, 1, 1, 2, 3, srau_pkg::SHIFT_ROR, 0, 0, 3),
                     32'h1, 32'h2, 32'h0, 1, 1);
        send_request(encode_insn(srau_pkg::OP_AND, 1, 1, 2, 3, srau_pkg::SHIFT_ROR, 0, 0, 3),
                     32'h1, 32'h2, 32'h0, 1, 1);
        send_request(encode_insn(srau_pkg::OP_ORR, 0, 1, 2, 0, srau_pkg::SHIFT_LSL, 0, 0, 3),
                     32'h0, 32'h0, 32'h0, 0, 0);
        send_request(encode_insn(srau_pkg::OP_ADD, 1, 1, 2, 0, srau_pkg::SHIFT_LSR, 1, 4, 3),
                     32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_001F, 1, 1);
    endtask

    task automatic run_random();
        logic [31:0] insn;
        int          roll;
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            quiet_phase = (i >= RANDOM_COUNT - QUIET_TAIL);
            maybe_idle_sender();
            insn = $urandom;
            roll = $urandom_range(0, 99);
            // Mostly legal opcode and shift type, some legal opcode only, the rest noise.
            if (roll < 88)
            begin
                insn[24:21] = legal_ops[$urandom_range(0, 6)];
                insn[6:5]   = 2'($urandom_range(0, 2));
            end
            else if (roll < 94)
                insn[24:21] = legal_ops[$urandom_range(0, 6)];
            send_request(insn, pick_operand(), pick_operand(), pick_shift_reg(),
                         $urandom_range(0, 1), $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // The receiver stalls in short bursts, and once long enough to back up the input.
    initial
    begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (!long_hold_done && sent_count >= 400)
            begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/srau_pkg.sv
rtl/core/shifted_register_alu_unit.sv
rtl/core/srau_checker.sv
tb/srau_result_checker.sv
tb/shifted_register_alu_unit_tb.sv
